>>> rtl/core/srt_pkg.sv
`timescale 1ns / 1ps

package srt_pkg;

    // Sizes
    localparam int MAX_SLOTS  = 16;
    localparam int SLOT_W     = $clog2(MAX_SLOTS);
    localparam int CNT_W      = 5;
    localparam int TIME_W     = 16;
    localparam int SUM_W      = 20;
    localparam int TICK_LIMIT = 99;

    localparam logic [CNT_W-1:0]  CNT_MAX   = {CNT_W{1'b1}};
    localparam logic [SUM_W-1:0]  SUM_MAX   = {SUM_W{1'b1}};
    localparam logic [TIME_W-1:0] TICK_MAX  = {TIME_W{1'b1}};
    localparam logic [TIME_W-1:0] TICK_LAST = TIME_W'(TICK_LIMIT);
    localparam logic [CNT_W-1:0]  SLOTS_CNT = CNT_W'(MAX_SLOTS);

    // Input operation codes
    localparam logic OPER_LOAD = 1'b0;
    localparam logic OPER_TICK = 1'b1;

    // Microprogram addresses
    localparam int STEP_W = 3;
    typedef logic [STEP_W-1:0] step_t;

    localparam step_t STEP_WAIT  = 3'd0;
    localparam step_t STEP_CHECK = 3'd1;
    localparam step_t STEP_SCAN  = 3'd2;
    localparam step_t STEP_PICK  = 3'd3;
    localparam step_t STEP_TOTAL = 3'd4;
    localparam step_t STEP_ADV   = 3'd5;
    localparam step_t STEP_EMIT  = 3'd6;

    // Datapath operation of one control word
    typedef enum logic [2:0] {
        OP_NONE,
        OP_WAIT,
        OP_CHECK,
        OP_SCAN,
        OP_PICK,
        OP_TOTAL,
        OP_ADV,
        OP_EMIT
    } op_t;

    // Branch conditions
    typedef enum logic [2:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_TICK,
        C_STOP,
        C_SCAN_LEFT,
        C_OUT_BUSY
    } cond_t;

    // Control word: hold in place while hold is true, else jump when
    // jump is true, else fall through to the next step.
    typedef struct packed {
        op_t   op;
        cond_t hold;
        cond_t jump;
        step_t target;
    } ctl_t;

    // Control store
    function automatic ctl_t ctl_rom(input step_t step);
        ctl_t w;
        w = '{op: OP_NONE, hold: C_NEVER, jump: C_ALWAYS, target: STEP_WAIT};
        unique case (step)
            STEP_WAIT:  w = '{op: OP_WAIT,  hold: C_NO_TICK,   jump: C_NEVER,
                              target: STEP_WAIT};
            STEP_CHECK: w = '{op: OP_CHECK, hold: C_NEVER,     jump: C_STOP,
                              target: STEP_EMIT};
            STEP_SCAN:  w = '{op: OP_SCAN,  hold: C_SCAN_LEFT, jump: C_NEVER,
                              target: STEP_WAIT};
            STEP_PICK:  w = '{op: OP_PICK,  hold: C_NEVER,     jump: C_NEVER,
                              target: STEP_WAIT};
            STEP_TOTAL: w = '{op: OP_TOTAL, hold: C_NEVER,     jump: C_NEVER,
                              target: STEP_WAIT};
            STEP_ADV:   w = '{op: OP_ADV,   hold: C_NEVER,     jump: C_NEVER,
                              target: STEP_WAIT};
            STEP_EMIT:  w = '{op: OP_EMIT,  hold: C_OUT_BUSY,  jump: C_ALWAYS,
                              target: STEP_WAIT};
            default:    w = '{op: OP_NONE,  hold: C_NEVER,     jump: C_ALWAYS,
                              target: STEP_WAIT};
        endcase
        return w;
    endfunction

endpackage

>>> rtl/core/srt_if.sv
`timescale 1ns / 1ps

// Command channel: load or tick words
interface srt_cmd_if;
    logic                               valid;
    logic                               ready;
    logic                               operation;
    logic [srt_pkg::SLOT_W-1:0]         slot_index;
    logic [srt_pkg::TIME_W-1:0]         arrival;
    logic [srt_pkg::TIME_W-1:0]         burst;

    modport source (output valid, operation, slot_index, arrival, burst, input ready);
    modport sink   (input valid, operation, slot_index, arrival, burst, output ready);
endinterface

// Result channel: one word per tick
interface srt_res_if;
    logic                               valid;
    logic                               ready;
    logic                               stopped;
    logic                               idle;
    logic [srt_pkg::SLOT_W-1:0]         chosen_slot;
    logic                               finished;
    logic [srt_pkg::TIME_W-1:0]         turnaround;
    logic [srt_pkg::TIME_W-1:0]         waiting;
    logic [srt_pkg::TIME_W-1:0]         response;
    logic [srt_pkg::CNT_W-1:0]          done_count;
    logic [srt_pkg::SUM_W-1:0]          sum_turnaround;
    logic [srt_pkg::SUM_W-1:0]          sum_waiting;
    logic [srt_pkg::SUM_W-1:0]          sum_response;
    logic [srt_pkg::TIME_W-1:0]         elapsed_ticks;

    modport source (output valid, stopped, idle, chosen_slot, finished, turnaround,
                    waiting, response, done_count, sum_turnaround, sum_waiting,
                    sum_response, elapsed_ticks, input ready);
    modport sink   (input valid, stopped, idle, chosen_slot, finished, turnaround,
                    waiting, response, done_count, sum_turnaround, sum_waiting,
                    sum_response, elapsed_ticks, output ready);
endinterface

>>> rtl/core/shortest_remaining_time_scheduler_core.sv
`timescale 1ns / 1ps

// Channel   Dir  Handshake      Word
// cmd       in   valid/ready    operation, slot_index, arrival, burst
// res       out  valid/ready    tick result and running totals
// cfg       in   cfg_we         process_count (5 bits)
//
// A load word is written to the slot table in the wait step. For a tick word
// the scan of the slot table runs one slot per cycle over the n active slots.
// A stopped tick skips the scan. The result sits in an output register, so
// the next word is accepted while it waits; a stalled result holds the
// sequencer at its emit step only once a second result is ready.
// Reset clears the sequencer, remaining times, started marks and totals.

module shortest_remaining_time_scheduler_core
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [srt_pkg::CNT_W-1:0]    cfg_wdata,
    srt_cmd_if.sink                      cmd,
    srt_res_if.source                    res
);

    localparam int SW = srt_pkg::SLOT_W;
    localparam int TW = srt_pkg::TIME_W;
    localparam int CW = srt_pkg::CNT_W;
    localparam int UW = srt_pkg::SUM_W;
    localparam int NS = srt_pkg::MAX_SLOTS;

    // Slot tables
    logic [TW-1:0] arr_mem [NS];
    logic [TW-1:0] bst_mem [NS];
    logic [TW-1:0] frs_mem [NS];
    logic [TW-1:0] rem_reg [NS];
    logic [NS-1:0] started_reg;

    // Global state
    logic [CW-1:0] pc_reg;
    logic [TW-1:0] tick_reg;
    logic          ovf_reg;
    logic [CW-1:0] done_reg;
    logic [UW-1:0] sum_ta_reg;
    logic [UW-1:0] sum_wt_reg;
    logic [UW-1:0] sum_rsp_reg;

    // Per-tick working registers
    srt_pkg::step_t step_reg, step_next;
    logic [CW-1:0] idx_reg;
    logic [SW-1:0] best_reg;
    logic [TW-1:0] best_rem_reg;
    logic          found_reg;
    logic          stop_reg;
    logic          fin_reg;
    logic [TW:0]   ta_reg;
    logic [TW-1:0] wt_reg;
    logic [TW-1:0] rsp_reg;
    logic [TW-1:0] bst_reg;

    // Output register
    logic          res_valid_reg;

    srt_pkg::ctl_t ctl;
    logic          hold_hit;
    logic          jump_hit;
    logic          cmd_fire;
    logic          res_load;
    logic [CW-1:0] n_active;
    logic          stop_now;
    logic [SW-1:0] rd_addr;
    logic [TW-1:0] rd_arr;
    logic [TW-1:0] rd_rem;
    logic          take;
    logic [TW:0]   ta_now;
    logic [TW-1:0] rsp_now;
    logic [TW-1:0] wt_now;
    logic [UW:0]   sum_ta_add;
    logic [UW:0]   sum_wt_add;
    logic [UW:0]   sum_rsp_add;

    function automatic logic cond_eval(input srt_pkg::cond_t c, input logic no_tick,
                                       input logic stop, input logic scan_left,
                                       input logic out_busy);
        logic r;
        r = 1'b0;
        unique case (c)
            srt_pkg::C_NEVER:     r = 1'b0;
            srt_pkg::C_ALWAYS:    r = 1'b1;
            srt_pkg::C_NO_TICK:   r = no_tick;
            srt_pkg::C_STOP:      r = stop;
            srt_pkg::C_SCAN_LEFT: r = scan_left;
            srt_pkg::C_OUT_BUSY:  r = out_busy;
            default:              r = 1'b0;
        endcase
        return r;
    endfunction

    // Control word fetch and branch decode
    always_comb
    begin
        ctl       = srt_pkg::ctl_rom(step_reg);
        n_active  = (pc_reg > srt_pkg::SLOTS_CNT) ? srt_pkg::SLOTS_CNT : pc_reg;
        stop_now  = (done_reg >= n_active) || (tick_reg > srt_pkg::TICK_LAST) || ovf_reg;
        cmd_fire  = cmd.valid && cmd.ready;
        res_load  = (ctl.op == srt_pkg::OP_EMIT) && (!res_valid_reg || res.ready);
        hold_hit  = cond_eval(ctl.hold,
                              !(cmd_fire && cmd.operation == srt_pkg::OPER_TICK),
                              stop_now, idx_reg != n_active, !res_load);
        jump_hit  = cond_eval(ctl.jump,
                              !(cmd_fire && cmd.operation == srt_pkg::OPER_TICK),
                              stop_now, idx_reg != n_active, !res_load);
        if (hold_hit)
            step_next = step_reg;
        else if (jump_hit)
            step_next = ctl.target;
        else
            step_next = step_reg + srt_pkg::step_t'(1);
    end

    assign cmd.ready = (ctl.op == srt_pkg::OP_WAIT);

    // Table read port: scan index while scanning, chosen slot afterwards
    always_comb
    begin
        rd_addr = (ctl.op == srt_pkg::OP_SCAN) ? idx_reg[SW-1:0] : best_reg;
        rd_arr  = arr_mem[rd_addr];
        rd_rem  = rem_reg[rd_addr];
        take    = (idx_reg != n_active) && (rd_rem != '0) && (rd_arr <= tick_reg)
                  && (!found_reg || rd_rem < best_rem_reg);
        ta_now  = {1'b0, tick_reg} + (TW+1)'(1) - {1'b0, rd_arr};
        rsp_now = started_reg[rd_addr] ? frs_mem[rd_addr] : (tick_reg - rd_arr);
        wt_now  = (ta_reg >= {1'b0, bst_reg}) ? TW'(ta_reg - {1'b0, bst_reg}) : '0;
        sum_ta_add  = {1'b0, sum_ta_reg}  + (UW+1)'(ta_reg);
        sum_wt_add  = {1'b0, sum_wt_reg}  + (UW+1)'(wt_now);
        sum_rsp_add = {1'b0, sum_rsp_reg} + (UW+1)'(rsp_reg);
    end

    // Sequencer and control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= srt_pkg::STEP_WAIT;
            pc_reg        <= CW'(1);
            tick_reg      <= '0;
            ovf_reg       <= 1'b0;
            done_reg      <= '0;
            sum_ta_reg    <= '0;
            sum_wt_reg    <= '0;
            sum_rsp_reg   <= '0;
            found_reg     <= 1'b0;
            stop_reg      <= 1'b0;
            fin_reg       <= 1'b0;
            idx_reg       <= '0;
            res_valid_reg <= 1'b0;
            started_reg   <= '0;
            for (int i = 0; i < NS; i++)
            begin
                rem_reg[i] <= '0;
            end
        end
        else
        begin
            step_reg <= step_next;
            if (cfg_we)
                pc_reg <= cfg_wdata;

            if (res_load)
                res_valid_reg <= 1'b1;
            else if (res.ready)
                res_valid_reg <= 1'b0;

            unique case (ctl.op)
                srt_pkg::OP_WAIT:
                begin
                    if (cmd_fire && cmd.operation == srt_pkg::OPER_LOAD)
                    begin
                        rem_reg[cmd.slot_index]     <= cmd.burst;
                        started_reg[cmd.slot_index] <= 1'b0;
                    end
                end
                srt_pkg::OP_CHECK:
                begin
                    stop_reg  <= stop_now;
                    found_reg <= 1'b0;
                    fin_reg   <= 1'b0;
                    idx_reg   <= '0;
                end
                srt_pkg::OP_SCAN:
                begin
                    if (idx_reg != n_active)
                    begin
                        idx_reg <= idx_reg + CW'(1);
                        if (take)
                            found_reg <= 1'b1;
                    end
                end
                srt_pkg::OP_PICK:
                begin
                    if (found_reg)
                    begin
                        rem_reg[best_reg]     <= rd_rem - TW'(1);
                        started_reg[best_reg] <= 1'b1;
                        fin_reg               <= (rd_rem == TW'(1));
                    end
                end
                srt_pkg::OP_TOTAL:
                begin
                    if (fin_reg)
                    begin
                        sum_ta_reg  <= (sum_ta_add > (UW+1)'(srt_pkg::SUM_MAX))
                                       ? srt_pkg::SUM_MAX : sum_ta_add[UW-1:0];
                        sum_wt_reg  <= (sum_wt_add > (UW+1)'(srt_pkg::SUM_MAX))
                                       ? srt_pkg::SUM_MAX : sum_wt_add[UW-1:0];
                        sum_rsp_reg <= (sum_rsp_add > (UW+1)'(srt_pkg::SUM_MAX))
                                       ? srt_pkg::SUM_MAX : sum_rsp_add[UW-1:0];
                        if (done_reg != srt_pkg::CNT_MAX)
                            done_reg <= done_reg + CW'(1);
                    end
                end
                srt_pkg::OP_ADV:
                begin
                    if (tick_reg == srt_pkg::TICK_MAX)
                        ovf_reg <= 1'b1;
                    else
                        tick_reg <= tick_reg + TW'(1);
                end
                default:
                begin
                end
            endcase
        end
    end

    // Slot tables and payload registers, no reset
    always_ff @(posedge clk)
    begin
        unique case (ctl.op)
            srt_pkg::OP_WAIT:
            begin
                if (cmd_fire && cmd.operation == srt_pkg::OPER_LOAD)
                begin
                    arr_mem[cmd.slot_index] <= cmd.arrival;
                    bst_mem[cmd.slot_index] <= cmd.burst;
                end
            end
            srt_pkg::OP_CHECK:
            begin
                ta_reg  <= '0;
                wt_reg  <= '0;
                rsp_reg <= '0;
                best_reg <= '0;
            end
            srt_pkg::OP_SCAN:
            begin
                if (take)
                begin
                    best_reg     <= idx_reg[SW-1:0];
                    best_rem_reg <= rd_rem;
                end
            end
            srt_pkg::OP_PICK:
            begin
                if (found_reg)
                begin
                    if (!started_reg[best_reg])
                        frs_mem[best_reg] <= tick_reg - rd_arr;
                    rsp_reg <= rsp_now;
                    bst_reg <= bst_mem[best_reg];
                    if (rd_rem == TW'(1))
                        ta_reg <= ta_now;
                end
            end
            srt_pkg::OP_TOTAL:
            begin
                if (fin_reg)
                    wt_reg <= wt_now;
            end
            default:
            begin
            end
        endcase
    end

    // Result word register
    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            res.stopped        <= stop_reg;
            res.idle           <= !stop_reg && !found_reg;
            res.chosen_slot    <= found_reg ? best_reg : '0;
            res.finished       <= fin_reg;
            res.turnaround     <= ta_reg[TW-1:0];
            res.waiting        <= wt_reg;
            res.response       <= rsp_reg;
            res.done_count     <= done_reg;
            res.sum_turnaround <= sum_ta_reg;
            res.sum_waiting    <= sum_wt_reg;
            res.sum_response   <= sum_rsp_reg;
            res.elapsed_ticks  <= tick_reg;
        end
    end

    assign res.valid = res_valid_reg;

    // Checks
    a_done_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> done_reg >= $past(done_reg))
        else $error("completed count went down");

    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        step_reg == srt_pkg::STEP_SCAN |-> idx_reg <= n_active)
        else $error("scan index ran past active slots");

    a_pick_has_work: assert property (@(posedge clk) disable iff (!rst_n)
        (step_reg == srt_pkg::STEP_PICK && found_reg) |-> rem_reg[best_reg] != '0)
        else $error("chosen slot has no work left");

    a_stopped_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (res_load && stop_reg) |-> (!fin_reg && !found_reg))
        else $error("stopped tick carries a chosen slot");

endmodule

>>> test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    localparam int SLOT_W     = srt_pkg::SLOT_W;
    localparam int TIME_W     = srt_pkg::TIME_W;
    localparam int CNT_W      = srt_pkg::CNT_W;
    localparam int SUM_W      = srt_pkg::SUM_W;
    localparam int MAX_SLOTS  = srt_pkg::MAX_SLOTS;
    localparam int TICK_LIMIT = srt_pkg::TICK_LIMIT;

    localparam int SETTLE_CYCLES = 48;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int PHASES        = 7;

    // One command word as driven on the cmd channel
    typedef struct packed {
        logic              operation;
        logic [SLOT_W-1:0] slot_index;
        logic [TIME_W-1:0] arrival;
        logic [TIME_W-1:0] burst;
    } sched_cmd_t;

    // One tick result word
    typedef struct packed {
        logic              stopped;
        logic              idle;
        logic [SLOT_W-1:0] chosen_slot;
        logic              finished;
        logic [TIME_W-1:0] turnaround;
        logic [TIME_W-1:0] waiting;
        logic [TIME_W-1:0] response;
        logic [CNT_W-1:0]  done_count;
        logic [SUM_W-1:0]  sum_turnaround;
        logic [SUM_W-1:0]  sum_waiting;
        logic [SUM_W-1:0]  sum_response;
        logic [TIME_W-1:0] elapsed_ticks;
    } sched_result_t;

    // Per-word note: a hand-typed result replaces the predicted one
    typedef struct packed {
        logic          typed;
        sched_result_t result;
    } word_tag_t;

    // Directed stimulus row
    typedef struct packed {
        logic          is_cfg;
        logic [CNT_W-1:0] count;
        sched_cmd_t    word;
        logic          typed;
        sched_result_t result;
    } dir_row_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CNT_W-1:0] cfg_wdata;

    srt_cmd_if cmd_ch ();
    srt_res_if res_ch ();

    shortest_remaining_time_scheduler_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd_ch),
        .res       (res_ch)
    );

    // Scheduler state as predicted
    logic [TIME_W-1:0] m_arrival [MAX_SLOTS];
    logic [TIME_W-1:0] m_burst   [MAX_SLOTS];
    logic [TIME_W-1:0] m_remain  [MAX_SLOTS];
    logic [TIME_W-1:0] m_first   [MAX_SLOTS];
    logic              m_started [MAX_SLOTS];
    logic [TIME_W-1:0] m_tick;
    logic [CNT_W-1:0]  m_done;
    logic [SUM_W-1:0]  m_sum_ta;
    logic [SUM_W-1:0]  m_sum_wt;
    logic [SUM_W-1:0]  m_sum_rsp;
    logic              m_overflow;
    logic [CNT_W-1:0]  m_count;

    sched_result_t tick_results_due [$];
    word_tag_t     word_tags [$];
    dir_row_t      dir_table [$];

    int  mismatches;
    int  cycle_count;
    logic idle_on;
    logic hold_req;

    int phase_pc  [PHASES];
    int phase_len [PHASES];

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Cycle limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic logic [SUM_W-1:0] capped_sum(input logic [SUM_W-1:0] acc,
                                                    input int add);
        longint s;
        s = longint'(acc) + add;
        return (s > longint'(srt_pkg::SUM_MAX)) ? srt_pkg::SUM_MAX : SUM_W'(s);
    endfunction

    function automatic string result_text(input sched_result_t r);
        return $sformatf({"stop=%0d idle=%0d slot=%0d fin=%0d ta=%0d wt=%0d rsp=%0d ",
                          "done=%0d sta=%0d swt=%0d srsp=%0d tick=%0d"},
                         r.stopped, r.idle, r.chosen_slot, r.finished, r.turnaround,
                         r.waiting, r.response, r.done_count, r.sum_turnaround,
                         r.sum_waiting, r.sum_response, r.elapsed_ticks);
    endfunction

    // Apply one command word to the predicted state
    task automatic schedule_word(input sched_cmd_t w, output logic has_res,
                                 output sched_result_t r);
        int   n;
        int   t;
        int   best;
        int   ta;
        int   wt;
        int   rsp;
        logic found;
        r = '0;
        has_res = 1'b0;
        found = 1'b0;
        best = 0;
        ta = 0;
        wt = 0;
        rsp = 0;
        if (w.operation == srt_pkg::OPER_LOAD)
        begin
            m_arrival[w.slot_index] = w.arrival;
            m_burst[w.slot_index]   = w.burst;
            m_remain[w.slot_index]  = w.burst;
            m_started[w.slot_index] = 1'b0;
        end
        else
        begin
            has_res = 1'b1;
            n = (int'(m_count) > MAX_SLOTS) ? MAX_SLOTS : int'(m_count);
            t = int'(m_tick);
            if (int'(m_done) >= n || t > TICK_LIMIT || m_overflow)
                r.stopped = 1'b1;
            else
            begin
                // least remaining time among arrived slots, lowest slot on a tie
                for (int i = 0; i < n; i++)
                begin
                    if (m_remain[i] != '0 && int'(m_arrival[i]) <= t)
                    begin
                        if (!found || m_remain[i] < m_remain[best])
                        begin
                            best = i;
                            found = 1'b1;
                        end
                    end
                end
                if (!found)
                    r.idle = 1'b1;
                else
                begin
                    if (!m_started[best])
                    begin
                        m_started[best] = 1'b1;
                        m_first[best] = TIME_W'(t - int'(m_arrival[best]));
                    end
                    rsp = int'(m_first[best]);
                    m_remain[best] = m_remain[best] - TIME_W'(1);
                    if (m_remain[best] == '0)
                    begin
                        r.finished = 1'b1;
                        ta = t + 1 - int'(m_arrival[best]);
                        wt = (ta >= int'(m_burst[best])) ? ta - int'(m_burst[best]) : 0;
                        m_sum_ta  = capped_sum(m_sum_ta, ta);
                        m_sum_wt  = capped_sum(m_sum_wt, wt);
                        m_sum_rsp = capped_sum(m_sum_rsp, rsp);
                        if (m_done != srt_pkg::CNT_MAX)
                            m_done = m_done + CNT_W'(1);
                    end
                end
                if (t >= int'(srt_pkg::TICK_MAX))
                    m_overflow = 1'b1;
                else
                    m_tick = m_tick + TIME_W'(1);
            end
            r.chosen_slot    = found ? SLOT_W'(best) : '0;
            r.turnaround     = TIME_W'(ta);
            r.waiting        = TIME_W'(wt);
            r.response       = TIME_W'(rsp);
            r.done_count     = m_done;
            r.sum_turnaround = m_sum_ta;
            r.sum_waiting    = m_sum_wt;
            r.sum_response   = m_sum_rsp;
            r.elapsed_ticks  = m_tick;
        end
    endtask

    task automatic report_mismatch(input string what, input string want, input string got);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch (%s) at %0t: expected [%s] got [%s]",
                     what, $realtime, want, got);
    endtask

    // Scoreboard: results are checked before the same edge's command is predicted
    always @(posedge clk)
    begin : scoreboard
        sched_result_t got;
        sched_result_t want;
        sched_result_t pred;
        word_tag_t     tag;
        logic          has_res;
        if (rst_n)
        begin
            if (cfg_we)
                m_count = cfg_wdata;
            if (res_ch.valid && res_ch.ready)
            begin
                got.stopped        = res_ch.stopped;
                got.idle           = res_ch.idle;
                got.chosen_slot    = res_ch.chosen_slot;
                got.finished       = res_ch.finished;
                got.turnaround     = res_ch.turnaround;
                got.waiting        = res_ch.waiting;
                got.response       = res_ch.response;
                got.done_count     = res_ch.done_count;
                got.sum_turnaround = res_ch.sum_turnaround;
                got.sum_waiting    = res_ch.sum_waiting;
                got.sum_response   = res_ch.sum_response;
                got.elapsed_ticks  = res_ch.elapsed_ticks;
                if (tick_results_due.size() == 0)
                    report_mismatch("unexpected word", "none", result_text(got));
                else
                begin
                    want = tick_results_due.pop_front();
                    if (got !== want)
                        report_mismatch("field", result_text(want), result_text(got));
                end
            end
            if (cmd_ch.valid && cmd_ch.ready)
            begin
                tag = word_tags.pop_front();
                schedule_word({cmd_ch.operation, cmd_ch.slot_index, cmd_ch.arrival,
                               cmd_ch.burst}, has_res, pred);
                if (has_res)
                    tick_results_due.push_back(tag.typed ? tag.result : pred);
            end
        end
    end

    // Result side: random stall bursts, one long hold-off on request
    initial
    begin : receiver
        int stall;
        res_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                stall = 400;
            end
            else if (idle_on && $urandom_range(0, 9) == 0)
                stall = $urandom_range(1, 18);
            else
                stall = 0;
            res_ch.ready <= (stall == 0);
            if (stall > 1)
                repeat (stall - 1) @(negedge clk);
        end
    end

    // Drive one word; entered and left at a falling edge
    task automatic send_word(input sched_cmd_t w, input logic typed, input sched_result_t r);
        word_tag_t tag;
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            cmd_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge clk);
        end
        tag.typed = typed;
        tag.result = r;
        word_tags.push_back(tag);
        cmd_ch.valid      <= 1'b1;
        cmd_ch.operation  <= w.operation;
        cmd_ch.slot_index <= w.slot_index;
        cmd_ch.arrival    <= w.arrival;
        cmd_ch.burst      <= w.burst;
        @(posedge clk);
        while (!cmd_ch.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Wait until the block has nothing left to do
    task automatic settle_block();
        cmd_ch.valid <= 1'b0;
        while (tick_results_due.size() != 0 || word_tags.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_process_count(input logic [CNT_W-1:0] value);
        settle_block();
        cfg_wdata <= value;
        cfg_we    <= 1'b1;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic add_row(input logic is_cfg, input logic op, input int slot,
                           input int arr, input int bur, input logic typed,
                           input sched_result_t r);
        dir_row_t row;
        row.is_cfg = is_cfg;
        row.count = CNT_W'(slot);
        row.word = {op, SLOT_W'(slot), TIME_W'(arr), TIME_W'(bur)};
        row.typed = typed;
        row.result = r;
        dir_table.push_back(row);
    endtask

    // One well-formed burst of loads followed by ticks, with some noise loads
    task automatic run_episode(input int n_act, output int sent);
        int         loads;
        int         ticks;
        int         lim;
        sched_cmd_t w;
        loads = $urandom_range(1, 4);
        ticks = $urandom_range(1, 5);
        lim = (n_act == 0 || n_act > MAX_SLOTS) ? MAX_SLOTS : n_act;
        repeat (loads)
        begin
            w.operation = srt_pkg::OPER_LOAD;
            if ($urandom_range(0, 9) == 0)
            begin
                w.slot_index = SLOT_W'($urandom);
                w.arrival    = TIME_W'($urandom);
                w.burst      = TIME_W'($urandom);
            end
            else
            begin
                w.slot_index = ($urandom_range(0, 7) == 0) ? SLOT_W'($urandom)
                                                           : SLOT_W'($urandom_range(0, lim - 1));
                w.arrival    = ($urandom_range(0, 3) == 0) ? '0
                               : TIME_W'(int'(m_tick) + $urandom_range(0, 5));
                w.burst      = ($urandom_range(0, 11) == 0) ? '0
                               : TIME_W'($urandom_range(1, 6));
            end
            send_word(w, 1'b0, '0);
        end
        repeat (ticks)
        begin
            // fields other than the operation are don't-care on a tick
            w.operation  = srt_pkg::OPER_TICK;
            w.slot_index = SLOT_W'($urandom);
            w.arrival    = TIME_W'($urandom);
            w.burst      = TIME_W'($urandom);
            send_word(w, 1'b0, '0);
        end
        sent = loads + ticks;
    endtask

    // Stimulus
    initial
    begin : stimulus
        sched_result_t exp_idle;
        sched_result_t exp_stop;
        int phase_done;
        int sent;
        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_wdata         = '0;
        cmd_ch.valid      = 1'b0;
        cmd_ch.operation  = srt_pkg::OPER_LOAD;
        cmd_ch.slot_index = '0;
        cmd_ch.arrival    = '0;
        cmd_ch.burst      = '0;
        mismatches        = 0;
        cycle_count       = 0;
        idle_on           = 1'b1;
        hold_req          = 1'b0;
        m_tick            = '0;
        m_done            = '0;
        m_sum_ta          = '0;
        m_sum_wt          = '0;
        m_sum_rsp         = '0;
        m_overflow        = 1'b0;
        m_count           = CNT_W'(1);
        for (int i = 0; i < MAX_SLOTS; i++)
        begin
            m_arrival[i] = '0;
            m_burst[i]   = '0;
            m_remain[i]  = '0;
            m_first[i]   = '0;
            m_started[i] = 1'b0;
        end
        phase_pc  = '{5, 9, 16, 31, 1, 0, 16};
        phase_len = '{40, 40, 40, 40, 400, 400, 840};

        // first tick after reset: one active slot, never loaded
        exp_idle = '0;
        exp_idle.idle = 1'b1;
        exp_idle.elapsed_ticks = TIME_W'(1);
        // zero active slots: every tick is stopped, time does not move
        exp_stop = '0;
        exp_stop.stopped = 1'b1;
        exp_stop.elapsed_ticks = TIME_W'(1);

        add_row(1'b0, srt_pkg::OPER_TICK, 0, 0, 0, 1'b1, exp_idle);
        add_row(1'b1, srt_pkg::OPER_LOAD, 0, 0, 0, 1'b0, '0);
        add_row(1'b0, srt_pkg::OPER_TICK, 15, 65535, 65535, 1'b1, exp_stop);
        add_row(1'b1, srt_pkg::OPER_LOAD, 16, 0, 0, 1'b0, '0);
        // tie between slots 1 and 3, late short job, zero burst, huge jobs
        add_row(1'b0, srt_pkg::OPER_LOAD, 3, 0, 3, 1'b0, '0);
        add_row(1'b0, srt_pkg::OPER_LOAD, 1, 0, 3, 1'b0, '0);
        add_row(1'b0, srt_pkg::OPER_LOAD, 15, 65535, 65535, 1'b0, '0);
        add_row(1'b0, srt_pkg::OPER_LOAD, 7, 2, 1, 1'b0, '0);
        add_row(1'b0, srt_pkg::OPER_LOAD, 9, 0, 0, 1'b0, '0);
        add_row(1'b0, srt_pkg::OPER_LOAD, 0, 0, 65535, 1'b0, '0);
        add_row(1'b0, srt_pkg::OPER_TICK, 0, 0, 0, 1'b0, '0);
        add_row(1'b0, srt_pkg::OPER_TICK, 0, 0, 0, 1'b0, '0);
        add_row(1'b0, srt_pkg::OPER_TICK, 0, 0, 0, 1'b0, '0);
        // reload while running: slot 1 starts over
        add_row(1'b0, srt_pkg::OPER_LOAD, 1, 0, 2, 1'b0, '0);
        add_row(1'b0, srt_pkg::OPER_TICK, 0, 0, 0, 1'b0, '0);
        add_row(1'b0, srt_pkg::OPER_TICK, 0, 0, 0, 1'b0, '0);
        add_row(1'b0, srt_pkg::OPER_TICK, 0, 0, 0, 1'b0, '0);
        add_row(1'b0, srt_pkg::OPER_TICK, 0, 0, 0, 1'b0, '0);
        add_row(1'b0, srt_pkg::OPER_TICK, 0, 0, 0, 1'b0, '0);
        // count above the slot total acts as all slots
        add_row(1'b1, srt_pkg::OPER_LOAD, 31, 0, 0, 1'b0, '0);
        add_row(1'b0, srt_pkg::OPER_TICK, 0, 0, 0, 1'b0, '0);
        add_row(1'b0, srt_pkg::OPER_TICK, 0, 0, 0, 1'b0, '0);

        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed part
        foreach (dir_table[k])
        begin
            if (dir_table[k].is_cfg)
                write_process_count(dir_table[k].count);
            else
                send_word(dir_table[k].word, dir_table[k].typed, dir_table[k].result);
        end

        // random part, one process count per phase
        for (int p = 0; p < PHASES; p++)
        begin
            write_process_count(CNT_W'(phase_pc[p]));
            if (p == 4)
                hold_req = 1'b1;
            phase_done = 0;
            while (phase_done < phase_len[p])
            begin
                idle_on = (p != PHASES - 1) && ($urandom_range(0, 3) != 0);
                run_episode(phase_pc[p], sent);
                phase_done += sent;
            end
        end
        settle_block();

        if (mismatches == 0 && tick_results_due.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
